### hw/rtl/hctk_pkg.sv
// Shared types, codes and byte-class helpers for the cookie header tokenizer.
// No dependencies; imported by every other file of the block except hctk_stream_if.
package hctk_pkg;

  typedef enum logic [2:0] {
    SC_START, SC_NAME, SC_NAMESP, SC_EQUALS, SC_QUOTED, SC_BSLASH, SC_VALUE, SC_VALUESP
  } scan_t;

  typedef enum logic [2:0] {
    CP_VERSION, CP_VALUE, CP_PATH, CP_DOMAIN, CP_PORT
  } comp_t;

  typedef enum logic [2:0] {
    NM_VERSION, NM_PATH, NM_DOMAIN, NM_PORT, NM_OTHER
  } name_cls_t;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  localparam logic [2:0] ROLE_VERSION = 3'd0;
  localparam logic [2:0] ROLE_COOKIE  = 3'd1;
  localparam logic [2:0] ROLE_PATH    = 3'd2;
  localparam logic [2:0] ROLE_DOMAIN  = 3'd3;
  localparam logic [2:0] ROLE_PORT    = 3'd4;

  localparam logic [3:0] ERR_NONE  = 4'd0;
  localparam logic [3:0] ERR_ORDER = 4'd9;
  localparam logic [3:0] ERR_END   = 4'd10;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int NUM_NAMES = 4;

  localparam logic [7:0] NAME_TEXT [NUM_NAMES][8] = '{
    '{"$", "V", "e", "r", "s", "i", "o", "n"},
    '{"$", "P", "a", "t", "h", 8'h00, 8'h00, 8'h00},
    '{"$", "D", "o", "m", "a", "i", "n", 8'h00},
    '{"$", "P", "o", "r", "t", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{4'd8, 4'd5, 4'd7, 4'd5};

  typedef struct packed {
    scan_t       scan;
    comp_t       comp;
    logic [3:0]  npos;
    logic [3:0]  ncand;
    logic        failed;
  } hctk_state_t;

  localparam hctk_state_t ST_RESET = '{
    scan: SC_START, comp: CP_VERSION, npos: 4'd0, ncand: 4'hF, failed: 1'b0
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       attr_done;
    logic [2:0] attr_role;
    logic       held_cookie_done;
    logic       new_cookie_done;
    logic [3:0] error_code;
    logic       header_ok;
  } hctk_result_t;

  function automatic logic is_sp(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09;
  endfunction

  function automatic logic is_ctl(input logic [7:0] c);
    return c < 8'h20 || c == 8'h7F;
  endfunction

  function automatic logic is_chr(input logic [7:0] c);
    return !c[7];
  endfunction

  function automatic logic is_txt(input logic [7:0] c);
    return !is_ctl(c) || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

endpackage

### hw/rtl/hctk_stream_if.sv
// Valid/ready channel interfaces for header bytes in and token results out.
// Does not depend on hctk_pkg; widths are fixed.
interface hctk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;
  modport source (output valid, in_byte, is_final, input ready);
  modport sink (input valid, in_byte, is_final, output ready);
endinterface

interface hctk_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       attr_done;
  logic [2:0] attr_role;
  logic       held_cookie_done;
  logic       new_cookie_done;
  logic [3:0] error_code;
  logic       header_ok;
  modport source (output valid, out_byte, byte_kind, attr_done, attr_role, held_cookie_done,
                  new_cookie_done, error_code, header_ok, input ready);
  modport sink (input valid, out_byte, byte_kind, attr_done, attr_role, held_cookie_done,
                new_cookie_done, error_code, header_ok, output ready);
endinterface

### hw/rtl/hctk_name_match.sv
// Attribute-name matcher against the four dollar names: candidate update for one byte
// and classification of the name seen so far. Depends on hctk_pkg.
module hctk_name_match
  import hctk_pkg::*;
(
  input  logic [3:0] pos,
  input  logic [3:0] cand,
  input  logic [7:0] c,
  input  logic [3:0] base_pos,
  input  logic [3:0] base_cand,
  output logic [3:0] fed_pos,
  output logic [3:0] fed_cand,
  output name_cls_t  cls
);

  always_comb begin
    for (int k = 0; k < NUM_NAMES; k++) begin
      fed_cand[k] = base_cand[k] && (base_pos < NAME_LEN[k]) &&
                    (NAME_TEXT[k][base_pos[2:0]] == c);
    end
    fed_pos = (base_pos == 4'hF) ? base_pos : base_pos + 4'd1;
  end

  always_comb begin
    cls = NM_OTHER;
    for (int k = NUM_NAMES - 1; k >= 0; k--) begin
      if (cand[k] && pos == NAME_LEN[k]) begin
        cls = name_cls_t'(3'(k));
      end
    end
  end

endmodule

### hw/rtl/hctk_step.sv
// Per-byte scanner and attribute composer: next state and result for one header byte.
// Depends on hctk_pkg and hctk_name_match.
module hctk_step
  import hctk_pkg::*;
(
  input  hctk_state_t  st,
  input  logic [7:0]   c,
  input  logic         fin,
  output hctk_state_t  nx,
  output hctk_result_t res
);

  typedef struct packed {
    logic       done;
    logic [2:0] role;
    logic       held;
    logic       newd;
    logic       err;
    comp_t      next;
  } cmp_res_t;

  name_cls_t  cls;
  logic [3:0] base_pos;
  logic [3:0] base_cand;
  logic [3:0] fed_pos;
  logic [3:0] fed_cand;

  assign base_pos  = (st.scan == SC_START) ? ST_RESET.npos : st.npos;
  assign base_cand = (st.scan == SC_START) ? ST_RESET.ncand : st.ncand;

  hctk_name_match u_match (
    .pos       (st.npos),
    .cand      (st.ncand),
    .c         (c),
    .base_pos  (base_pos),
    .base_cand (base_cand),
    .fed_pos   (fed_pos),
    .fed_cand  (fed_cand),
    .cls       (cls)
  );

  function automatic cmp_res_t compose(input name_cls_t nm, input comp_t cs, input logic last);
    cmp_res_t r;
    logic     cookie;
    r = '0;
    r.next = cs;
    cookie = 1'b0;
    case (cs)
      CP_VERSION: begin
        if (nm == NM_VERSION) begin
          r.done = 1'b1;
          r.role = ROLE_VERSION;
          r.next = CP_VALUE;
        end else if (nm == NM_OTHER) begin
          cookie = 1'b1;
        end
      end
      CP_PATH, CP_DOMAIN, CP_PORT: begin
        if ((cs == CP_PATH && nm == NM_PATH) || (cs == CP_DOMAIN && nm == NM_DOMAIN) ||
            (cs == CP_PORT && nm == NM_PORT)) begin
          r.done = 1'b1;
          case (cs)
            CP_PATH:   r.role = ROLE_PATH;
            CP_DOMAIN: r.role = ROLE_DOMAIN;
            default:   r.role = ROLE_PORT;
          endcase
          if (cs == CP_PORT || last) begin
            r.newd = 1'b1;
            r.next = CP_VALUE;
          end else if (cs == CP_PATH) begin
            r.next = CP_DOMAIN;
          end else begin
            r.next = CP_PORT;
          end
        end else if (nm == NM_OTHER || nm == NM_VERSION) begin
          r.held = 1'b1;
          cookie = 1'b1;
        end
      end
      default: begin
        if (nm == NM_OTHER || nm == NM_VERSION) begin
          cookie = 1'b1;
        end
      end
    endcase
    if (cookie) begin
      r.done = 1'b1;
      r.role = ROLE_COOKIE;
      if (last) begin
        r.newd = 1'b1;
        r.next = CP_VALUE;
      end else begin
        r.next = CP_PATH;
      end
    end
    r.err = !r.done;
    return r;
  endfunction

  logic     sep;
  logic     bad;
  logic     do_cmp;
  cmp_res_t cr;

  assign sep = (st.scan inside {SC_NAME, SC_NAMESP, SC_EQUALS, SC_VALUE, SC_VALUESP}) &&
               (c == CH_SEMI || c == CH_COMMA);
  assign cr  = compose(cls, st.comp, sep ? (c == CH_COMMA) : 1'b1);

  always_comb begin
    nx     = st;
    res    = '0;
    bad    = 1'b0;
    do_cmp = 1'b0;
    if (!st.failed) begin
      if (sep) begin
        do_cmp  = 1'b1;
        nx.scan = SC_START;
      end else begin
        case (st.scan)
          SC_START: begin
            if (is_sp(c)) begin
            end else if (!is_ctl(c) && c != CH_EQUALS) begin
              nx.npos       = fed_pos;
              nx.ncand      = fed_cand;
              res.out_byte  = c;
              res.byte_kind = KIND_NAME;
              nx.scan       = SC_NAME;
            end else begin
              bad = 1'b1;
            end
          end
          SC_NAME: begin
            if (is_sp(c)) begin
              nx.scan = SC_NAMESP;
            end else if (c == CH_EQUALS) begin
              nx.scan = SC_EQUALS;
            end else if (!is_ctl(c)) begin
              nx.npos       = fed_pos;
              nx.ncand      = fed_cand;
              res.out_byte  = c;
              res.byte_kind = KIND_NAME;
            end else begin
              bad = 1'b1;
            end
          end
          SC_NAMESP: begin
            if (c == CH_EQUALS) begin
              nx.scan = SC_EQUALS;
            end else if (!is_sp(c)) begin
              bad = 1'b1;
            end
          end
          SC_EQUALS: begin
            if (c == CH_QUOTE) begin
              nx.scan = SC_QUOTED;
            end else if (is_sp(c)) begin
            end else if (is_chr(c) && !is_ctl(c)) begin
              res.out_byte  = c;
              res.byte_kind = KIND_VALUE;
              nx.scan       = SC_VALUE;
            end else begin
              bad = 1'b1;
            end
          end
          SC_QUOTED: begin
            if (c == CH_QUOTE) begin
              nx.scan = SC_VALUESP;
            end else if (c == CH_BSLASH) begin
              nx.scan = SC_BSLASH;
            end else if (is_txt(c)) begin
              res.out_byte  = c;
              res.byte_kind = KIND_VALUE;
            end else begin
              bad = 1'b1;
            end
          end
          SC_BSLASH: begin
            if (is_chr(c)) begin
              res.out_byte  = c;
              res.byte_kind = KIND_VALUE;
              nx.scan       = SC_QUOTED;
            end else begin
              bad = 1'b1;
            end
          end
          SC_VALUE: begin
            if (is_sp(c)) begin
              nx.scan = SC_VALUESP;
            end else if (is_chr(c) && !is_ctl(c)) begin
              res.out_byte  = c;
              res.byte_kind = KIND_VALUE;
            end else begin
              bad = 1'b1;
            end
          end
          default: begin
            if (!is_sp(c)) begin
              bad = 1'b1;
            end
          end
        endcase
      end

      // end of header: value states close the attribute, others are premature
      if (!bad && fin && !sep) begin
        if (nx.scan inside {SC_EQUALS, SC_VALUE, SC_VALUESP}) begin
          do_cmp        = 1'b1;
          res.header_ok = !cr.err;
        end else begin
          res.error_code = ERR_END;
          nx.failed      = 1'b1;
        end
      end

      if (do_cmp) begin
        nx.npos  = ST_RESET.npos;
        nx.ncand = ST_RESET.ncand;
        if (cr.err) begin
          res.error_code = ERR_ORDER;
          nx.failed      = 1'b1;
        end else begin
          res.attr_done        = 1'b1;
          res.attr_role        = cr.role;
          res.held_cookie_done = cr.held;
          res.new_cookie_done  = cr.newd;
          nx.comp              = cr.next;
          if (fin && sep) begin
            res.error_code = ERR_END;
            nx.failed      = 1'b1;
          end
        end
      end

      if (bad) begin
        res            = '0;
        res.error_code = {1'b0, st.scan} + 4'd1;
        nx.failed      = 1'b1;
      end
    end
    if (fin) begin
      nx = ST_RESET;
    end
  end

endmodule

### hw/rtl/http_cookie_header_tokenizer.sv
// Cookie header tokenizer top level: input register, parse state, result register.
// Depends on hctk_pkg, hctk_stream_if and hctk_step.
//
// Usage:
//   hdr carries one header byte per request with is_final on the last byte.
//   tok returns exactly one result per byte: the byte tagged as name or value
//   (or dropped), attribute end with its role, cookie completion flags, an
//   error code, and header_ok on a cleanly ended final byte.
//   A byte taken is first held in the input register, and its result is
//   loaded into the result register when that byte moves on.
//   Throughput is one byte per cycle unless tok stalls; the path from input
//   register to result register is a single pass of the scanner and composer logic.
//   hdr.ready stays high while the input register is empty or moving on, so a
//   new byte is taken even while a finished result waits on tok.
//   When tok stalls, the result and the byte behind it hold; hdr.ready drops
//   once both registers are full.
//   After an error every further byte of the header yields an all-zero result.
//   Every final byte returns the parser to its reset state for the next header.
//   rst (synchronous) empties both registers and restores the reset state.
module http_cookie_header_tokenizer
  import hctk_pkg::*;
(
  input logic        clk,
  input logic        rst,
  hctk_in_if.sink    hdr,
  hctk_out_if.source tok
);

  logic         in_vld;
  logic [7:0]   in_c;
  logic         in_fin;
  hctk_state_t  st;
  hctk_state_t  st_next;
  hctk_result_t res;
  hctk_result_t res_next;
  logic         out_vld;
  logic         adv;

  assign adv       = in_vld && (!out_vld || tok.ready);
  assign hdr.ready = !in_vld || adv;

  hctk_step u_step (
    .st  (st),
    .c   (in_c),
    .fin (in_fin),
    .nx  (st_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      st      <= ST_RESET;
    end else begin
      if (hdr.valid && hdr.ready) begin
        in_vld <= 1'b1;
        in_c   <= hdr.in_byte;
        in_fin <= hdr.is_final;
      end else if (adv) begin
        in_vld <= 1'b0;
      end
      if (adv) begin
        st      <= st_next;
        res     <= res_next;
        out_vld <= 1'b1;
      end else if (tok.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  assign tok.valid            = out_vld;
  assign tok.out_byte         = res.out_byte;
  assign tok.byte_kind        = res.byte_kind;
  assign tok.attr_done        = res.attr_done;
  assign tok.attr_role        = res.attr_role;
  assign tok.held_cookie_done = res.held_cookie_done;
  assign tok.new_cookie_done  = res.new_cookie_done;
  assign tok.error_code       = res.error_code;
  assign tok.header_ok        = res.header_ok;

  a_failed_silent: assert property (@(posedge clk) disable iff (rst)
    adv && st.failed |=> res == '0)
    else $error("result not zero while header failed");

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    adv && in_fin |=> st == ST_RESET)
    else $error("state not restored after final byte");

  a_ok_no_error: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !(res.header_ok && res.error_code != ERR_NONE))
    else $error("header_ok with error code");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    in_vld && !adv |=> in_vld && $stable(in_c) && $stable(in_fin))
    else $error("stalled input byte lost");

  a_failed_latched: assert property (@(posedge clk) disable iff (rst)
    adv && !in_fin && res_next.error_code != ERR_NONE |=> st.failed)
    else $error("error without failed state");

endmodule
